### hdl/swd_pkg.sv
// ----------------------------------------------------------------------------
// swd_pkg: shared constants and tables for the swerve wheel block
// Widths of the CORDIC datapaths, the gain correction and the arctangent table.
// ----------------------------------------------------------------------------
package swd_pkg;

  localparam int GUARD   = 8;
  localparam int ITERS   = 20;
  localparam int KINV    = 39797;
  localparam int CW      = 28;   // CORDIC x/y width
  localparam int ZW      = 34;   // CORDIC angle width
  localparam int SPW     = 17;   // unscaled speed width
  localparam int REG_COUNT = 8;

  localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;

  // arctangent of 2^-i in 32-bit binary angle units
  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051D;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2E;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // clamp a 24-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) r = 16'sh7FFF;
    else if (v < -24'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

### hdl/swerve_wheel_speed_direction.sv
// ----------------------------------------------------------------------------
// swerve_wheel_speed_direction: four-wheel swerve inverse kinematics
// Drive command in, speed and steering angle for four wheels out.
// ----------------------------------------------------------------------------
// Fully pipelined: one command is accepted every cycle unless the output stalls.
// Each command passes through the 20-cell rotation CORDIC chain, the four
// 20-cell vectoring CORDIC lanes and the FRAC_BITS+1 cell normalizing divider.
// The whole pipeline holds while a result waits on m_tready. Multiplier
// registers are written through cfg_we/cfg_index/cfg_data; indexes 8 and up
// are ignored.
module swerve_wheel_speed_direction #(
  parameter int FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vel_x[15:0], vel_y[31:16], spin_rate[47:32], heading[63:48]
  input  logic [63:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // per wheel w (29 bits from 29*w): speed[12:0], direction[28:13]; zero pad
  output logic [119:0] m_tdata,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_index,
  input  logic [13:0]  cfg_data
);

  localparam int CW  = swd_pkg::CW;
  localparam int ZW  = swd_pkg::ZW;
  localparam int SPW = swd_pkg::SPW;
  localparam int IT  = swd_pkg::ITERS;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = SPW + FRAC_BITS + 1;
  localparam int L   = 1 + IT + 3 + IT + 4 + QW;

  logic en;
  logic [L-1:0] vp;
  logic signed [13:0] mreg [0:3][0:1];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vp[L-1];

  // shift item valids and write multipliers
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
      for (int w = 0; w < 4; w++) begin
        mreg[w][0] <= '0;
        mreg[w][1] <= '0;
      end
    end else begin
      if (en) vp <= {vp[L-2:0], s_tvalid};
      if (cfg_we && cfg_index < 4'(swd_pkg::REG_COUNT))
        mreg[cfg_index[2:1]][cfg_index[0]] <= cfg_data;
    end
  end

  // input stage: quarter turn minus heading, fold into +-quarter turn
  logic signed [CW-1:0] ra [0:IT];
  logic signed [CW-1:0] rb [0:IT];
  logic signed [ZW-1:0] rz [0:IT];
  logic signed [15:0]   rs [0:IT];
  logic [15:0] th;
  logic signed [CW-1:0] a0, b0;
  logic signed [ZW-1:0] z0;

  always_comb begin
    th = 16'd16384 - s_tdata[63:48];
    a0 = {{(CW-24){s_tdata[15]}}, s_tdata[15:0], 8'b0};
    b0 = {{(CW-24){s_tdata[31]}}, s_tdata[31:16], 8'b0};
    z0 = {{(ZW-32){th[15]}}, th, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs[0] <= s_tdata[47:32];
      if (z0 > swd_pkg::QUARTER_TURN) begin
        ra[0] <= -a0; rb[0] <= -b0; rz[0] <= z0 - swd_pkg::HALF_TURN;
      end else if (z0 < -swd_pkg::QUARTER_TURN) begin
        ra[0] <= -a0; rb[0] <= -b0; rz[0] <= z0 + swd_pkg::HALF_TURN;
      end else begin
        ra[0] <= a0; rb[0] <= b0; rz[0] <= z0;
      end
    end
  end

  for (genvar i = 0; i < IT; i++) begin : g_rot
    swd_rot_cell #(.STAGE(i)) u_cell (
      .clk(clk), .en(en),
      .in_a(ra[i]), .in_b(rb[i]), .in_z(rz[i]), .in_spin(rs[i]),
      .out_a(ra[i+1]), .out_b(rb[i+1]), .out_z(rz[i+1]), .out_spin(rs[i+1])
    );
  end

  // gain correction and multiplier products
  logic signed [45:0] pa, pb;
  logic signed [29:0] pmx [0:3];
  logic signed [29:0] pmy [0:3];
  logic signed [15:0] rx, ry;
  logic signed [21:0] mxs [0:3];
  logic signed [21:0] mys [0:3];
  logic signed [45:0] rpa, rpb;
  logic signed [29:0] half_m;

  assign half_m = 30'sd1 <<< (FRAC_BITS - 1);
  assign rpa    = pa + 46'sd8388608;
  assign rpb    = pb + 46'sd8388608;

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= ra[IT] * $signed({1'b0, 17'(swd_pkg::KINV)});
      pb <= rb[IT] * $signed({1'b0, 17'(swd_pkg::KINV)});
      for (int w = 0; w < 4; w++) begin
        pmx[w] <= mreg[w][0] * rs[IT];
        pmy[w] <= mreg[w][1] * rs[IT];
      end
      rx <= swd_pkg::sat16({{2{rpa[45]}}, rpa[45:24]});
      ry <= swd_pkg::sat16({{2{rpb[45]}}, rpb[45:24]});
      for (int w = 0; w < 4; w++) begin
        mxs[w] <= 22'((pmx[w] + half_m) >>> FRAC_BITS);
        mys[w] <= 22'((pmy[w] + half_m) >>> FRAC_BITS);
      end
    end
  end

  // wheel sums and vectoring setup
  logic signed [CW-1:0] va [0:3][0:IT];
  logic signed [CW-1:0] vb [0:3][0:IT];
  logic signed [ZW-1:0] vz [0:3][0:IT];
  logic                 vzr [0:3][0:IT];
  logic signed [15:0] wx [0:3];
  logic signed [15:0] wy [0:3];

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      wx[w] = swd_pkg::sat16(24'(mxs[w]) + 24'(rx));
      wy[w] = swd_pkg::sat16(24'(mys[w]) - 24'(ry));
    end
  end

  for (genvar w = 0; w < 4; w++) begin : g_vset
    always_ff @(posedge clk) begin
      if (en) begin
        vzr[w][0] <= (wx[w] == 16'sd0) && (wy[w] == 16'sd0);
        if (wy[w] < 0) begin
          va[w][0] <= -{{(CW-24){wy[w][15]}}, wy[w], 8'b0};
          vb[w][0] <= -{{(CW-24){wx[w][15]}}, wx[w], 8'b0};
          vz[w][0] <= swd_pkg::HALF_TURN;
        end else begin
          va[w][0] <= {{(CW-24){wy[w][15]}}, wy[w], 8'b0};
          vb[w][0] <= {{(CW-24){wx[w][15]}}, wx[w], 8'b0};
          vz[w][0] <= '0;
        end
      end
    end
  end

  for (genvar w = 0; w < 4; w++) begin : g_lane
    for (genvar i = 0; i < IT; i++) begin : g_vec
      swd_vec_cell #(.STAGE(i)) u_cell (
        .clk(clk), .en(en),
        .in_a(va[w][i]), .in_b(vb[w][i]), .in_z(vz[w][i]), .in_zero(vzr[w][i]),
        .out_a(va[w][i+1]), .out_b(vb[w][i+1]), .out_z(vz[w][i+1]),
        .out_zero(vzr[w][i+1])
      );
    end
  end

  // magnitude gain, direction rounding, zero vector
  logic signed [45:0] pd [0:3];
  logic [15:0] d4 [0:3];
  logic        zr4 [0:3];
  logic [SPW-1:0] sp5 [0:3];
  logic [15:0] d5 [0:3];
  logic signed [45:0] rd [0:3];
  logic signed [ZW-1:0] zd [0:3];

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      rd[w] = pd[w] + 46'sd8388608;
      zd[w] = vz[w][IT] + 34'sd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < 4; w++) begin
        pd[w]  <= va[w][IT] * $signed({1'b0, 17'(swd_pkg::KINV)});
        d4[w]  <= zd[w][31:16];
        zr4[w] <= vzr[w][IT];
        if (zr4[w] || rd[w][45]) sp5[w] <= '0;
        else sp5[w] <= rd[w][24+SPW-1:24];
        d5[w] <= zr4[w] ? 16'd0 : d4[w];
      end
    end
  end

  // largest speed
  logic [SPW-1:0] sp6 [0:3];
  logic [15:0] d6 [0:3];
  logic [SPW-1:0] mx01, mx23, mx6;
  logic [SPW-1:0] one_q;

  assign mx01  = (sp5[1] > sp5[0]) ? sp5[1] : sp5[0];
  assign mx23  = (sp5[3] > sp5[2]) ? sp5[3] : sp5[2];
  assign one_q = SPW'(1) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < 4; w++) begin
        sp6[w] <= sp5[w];
        d6[w]  <= d5[w];
      end
      mx6 <= (mx23 > mx01) ? mx23 : mx01;
    end
  end

  // divider setup: numerator s*ONE + max/2, bypass when max fits
  logic [NW-1:0]  dn [0:3][0:QW];
  logic [SPW-1:0] dd [0:3][0:QW];
  logic [QW-1:0]  dq [0:3][0:QW];
  logic           db [0:3][0:QW];
  logic [15:0]    ddir [0:3][0:QW];
  logic           byp;

  assign byp = mx6 <= one_q;

  for (genvar w = 0; w < 4; w++) begin : g_dset
    always_ff @(posedge clk) begin
      if (en) begin
        dn[w][0]   <= (NW'(sp6[w]) << FRAC_BITS) + NW'(mx6 >> 1);
        dd[w][0]   <= mx6;
        dq[w][0]   <= byp ? sp6[w][QW-1:0] : '0;
        db[w][0]   <= byp;
        ddir[w][0] <= d6[w];
      end
    end
  end

  for (genvar w = 0; w < 4; w++) begin : g_dlane
    for (genvar j = 0; j < QW; j++) begin : g_div
      swd_div_cell #(.NW(NW), .QW(QW), .K(FRAC_BITS - j)) u_cell (
        .clk(clk), .en(en),
        .in_n(dn[w][j]), .in_d(dd[w][j]), .in_q(dq[w][j]), .in_bypass(db[w][j]),
        .in_dir(ddir[w][j]),
        .out_n(dn[w][j+1]), .out_d(dd[w][j+1]), .out_q(dq[w][j+1]),
        .out_bypass(db[w][j+1]), .out_dir(ddir[w][j+1])
      );
    end
  end

  // pack results
  logic [QW+12:0] qx [0:3];

  always_comb begin
    m_tdata = '0;
    for (int w = 0; w < 4; w++) begin
      qx[w] = {13'b0, dq[w][QW]};
      m_tdata[29*w +: 13]      = qx[w][12:0];
      m_tdata[29*w + 13 +: 16] = ddir[w][QW];
    end
  end

endmodule

### hdl/swd_rot_cell.sv
// ----------------------------------------------------------------------------
// swd_rot_cell: one rotation-mode CORDIC step
// Turns the vector by the table angle of this step toward zero residual angle.
// ----------------------------------------------------------------------------
module swd_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [swd_pkg::CW-1:0] in_a,
  input  logic signed [swd_pkg::CW-1:0] in_b,
  input  logic signed [swd_pkg::ZW-1:0] in_z,
  input  logic signed [15:0]            in_spin,
  output logic signed [swd_pkg::CW-1:0] out_a,
  output logic signed [swd_pkg::CW-1:0] out_b,
  output logic signed [swd_pkg::ZW-1:0] out_z,
  output logic signed [15:0]            out_spin
);

  logic signed [swd_pkg::CW-1:0] sa, sb;
  logic signed [swd_pkg::ZW-1:0] at;

  assign sa = in_a >>> STAGE;
  assign sb = in_b >>> STAGE;
  assign at = {{(swd_pkg::ZW-32){1'b0}}, swd_pkg::atan_entry(STAGE)};

  // advance one micro-rotation
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_z >= 0) begin
        out_a <= in_a - sb;
        out_b <= in_b + sa;
        out_z <= in_z - at;
      end else begin
        out_a <= in_a + sb;
        out_b <= in_b - sa;
        out_z <= in_z + at;
      end
      out_spin <= in_spin;
    end
  end

endmodule

### hdl/swd_vec_cell.sv
// ----------------------------------------------------------------------------
// swd_vec_cell: one vectoring-mode CORDIC step
// Drives the vector onto the positive axis while summing the angle.
// ----------------------------------------------------------------------------
module swd_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic en,
  input  logic signed [swd_pkg::CW-1:0] in_a,
  input  logic signed [swd_pkg::CW-1:0] in_b,
  input  logic signed [swd_pkg::ZW-1:0] in_z,
  input  logic                          in_zero,
  output logic signed [swd_pkg::CW-1:0] out_a,
  output logic signed [swd_pkg::CW-1:0] out_b,
  output logic signed [swd_pkg::ZW-1:0] out_z,
  output logic                          out_zero
);

  logic signed [swd_pkg::CW-1:0] sa, sb;
  logic signed [swd_pkg::ZW-1:0] at;

  assign sa = in_a >>> STAGE;
  assign sb = in_b >>> STAGE;
  assign at = {{(swd_pkg::ZW-32){1'b0}}, swd_pkg::atan_entry(STAGE)};

  // advance one micro-rotation
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_b >= 0) begin
        out_a <= in_a + sb;
        out_b <= in_b - sa;
        out_z <= in_z + at;
      end else begin
        out_a <= in_a - sb;
        out_b <= in_b + sa;
        out_z <= in_z - at;
      end
      out_zero <= in_zero;
    end
  end

endmodule

### hdl/swd_div_cell.sv
// ----------------------------------------------------------------------------
// swd_div_cell: one restoring-division step
// Produces quotient bit K of the speed normalization; bypassed items pass.
// ----------------------------------------------------------------------------
module swd_div_cell #(
  parameter int NW = 30,
  parameter int QW = 13,
  parameter int K  = 0
) (
  input  logic clk,
  input  logic en,
  input  logic [NW-1:0]          in_n,
  input  logic [swd_pkg::SPW-1:0] in_d,
  input  logic [QW-1:0]          in_q,
  input  logic                   in_bypass,
  input  logic [15:0]            in_dir,
  output logic [NW-1:0]          out_n,
  output logic [swd_pkg::SPW-1:0] out_d,
  output logic [QW-1:0]          out_q,
  output logic                   out_bypass,
  output logic [15:0]            out_dir
);

  logic [NW-1:0] dk;

  assign dk = NW'(in_d) << K;

  // subtract the shifted divisor when it fits
  always_ff @(posedge clk) begin
    if (en) begin
      if (!in_bypass && in_n >= dk) begin
        out_n    <= in_n - dk;
        out_q    <= in_q | (QW'(1) << K);
      end else begin
        out_n    <= in_n;
        out_q    <= in_q;
      end
      out_d      <= in_d;
      out_bypass <= in_bypass;
      out_dir    <= in_dir;
    end
  end

endmodule

### dv/swerve_wheel_speed_direction_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerve_wheel_speed_direction_monitor: result checker for the swerve block
// Watches both stream channels, predicts the wheel speeds and directions of
// every accepted drive command and compares them field by field, in order.
// ----------------------------------------------------------------------------
module swerve_wheel_speed_direction_monitor (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [63:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_index,
  input  logic [13:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           result_count
);

  localparam int FRAC = 12;
  localparam longint ONE_Q = 64'sd1 << FRAC;

  typedef struct packed {
    logic [15:0] direction;
    logic [12:0] speed;
  } wheel_out_t;

  logic signed [13:0] mult_x [4];
  logic signed [13:0] mult_y [4];
  wheel_out_t wheel_queue [$];

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    longint t [20] = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
                       64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                       64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
                       64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
                       64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517};
    return t[i];
  endfunction

  // work out the four wheel outputs of one drive command
  function automatic void predict_wheels(logic [63:0] cmd);
    longint vx, vy, spin, th, a, b, z, na, nb, rx, ry, x, y, maxs;
    longint spd [4];
    logic [15:0] dir [4];
    vx = longint'($signed(cmd[15:0]));
    vy = longint'($signed(cmd[31:16]));
    spin = longint'($signed(cmd[47:32]));
    th = longint'(16'(16'd16384 - cmd[63:48]));
    if (th >= 32768) th -= 65536;
    z = th * 65536;
    a = vx * 256;
    b = vy * 256;
    // fold angles past a quarter turn
    if (z > 64'sd1073741824) begin
      a = -a; b = -b; z -= 64'sd2147483648;
    end else if (z < -64'sd1073741824) begin
      a = -a; b = -b; z += 64'sd2147483648;
    end
    for (int i = 0; i < 20; i++) begin
      if (z >= 0) begin
        na = a - shr(b, i); nb = b + shr(a, i); z -= atan_step(i);
      end else begin
        na = a + shr(b, i); nb = b - shr(a, i); z += atan_step(i);
      end
      a = na; b = nb;
    end
    rx = clamp16(rnd(a * 39797, 24));
    ry = clamp16(rnd(b * 39797, 24));
    maxs = 0;
    for (int w = 0; w < 4; w++) begin
      x = clamp16(rnd(longint'(mult_x[w]) * spin, FRAC) + rx);
      y = clamp16(rnd(longint'(mult_y[w]) * spin, FRAC) - ry);
      spd[w] = 0;
      dir[w] = '0;
      if (x != 0 || y != 0) begin
        a = y * 256; b = x * 256; z = 0;
        if (a < 0) begin
          a = -a; b = -b; z = 64'sd2147483648;
        end
        for (int i = 0; i < 20; i++) begin
          if (b >= 0) begin
            na = a + shr(b, i); nb = b - shr(a, i); z += atan_step(i);
          end else begin
            na = a - shr(b, i); nb = b + shr(a, i); z -= atan_step(i);
          end
          a = na; b = nb;
        end
        dir[w] = 16'((z + 32768 + (64'sd1 << 33)) >>> 16);
        spd[w] = rnd(a * 39797, 24);
        if (spd[w] < 0) spd[w] = 0;
      end
      if (spd[w] > maxs) maxs = spd[w];
    end
    // scale down when any wheel would exceed full speed
    for (int w = 0; w < 4; w++) begin
      if (maxs > ONE_Q) spd[w] = (spd[w] * ONE_Q + maxs / 2) / maxs;
      wheel_queue.push_back('{direction: dir[w], speed: 13'(spd[w])});
    end
  endfunction

  always @(posedge clk) begin
    wheel_out_t want;
    logic [28:0] got;
    int errs;
    errs = 0;
    if (rst) begin
      for (int w = 0; w < 4; w++) begin
        mult_x[w] <= '0;
        mult_y[w] <= '0;
      end
      wheel_queue.delete();
      fail_count <= 0;
      result_count <= 0;
      pending <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_wheels(s_tdata);
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        if (wheel_queue.size() == 0) begin
          $error("wheel result with no command waiting: %h", m_tdata);
          errs++;
        end else begin
          for (int w = 0; w < 4; w++) begin
            want = wheel_queue.pop_front();
            got = m_tdata[29*w +: 29];
            if (got[12:0] != want.speed) begin
              $error("wheel%0d_speed expected %0d got %0d", w, want.speed, got[12:0]);
              errs++;
            end
            if (got[28:13] != want.direction) begin
              $error("wheel%0d_direction expected %0d got %0d", w, want.direction,
                     got[28:13]);
              errs++;
            end
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= wheel_queue.size() / 4;
      // register writes land after this cycle's prediction
      if (cfg_we && cfg_index < swd_pkg::REG_COUNT) begin
        if (cfg_index[0]) mult_y[cfg_index >> 1] <= cfg_data;
        else mult_x[cfg_index >> 1] <= cfg_data;
      end
    end
  end
endmodule

### dv/swerve_wheel_speed_direction_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerve_wheel_speed_direction_test: stimulus for the swerve wheel block
// Sets wheel multipliers across several settings, sends directed and random
// drive commands with random gaps and stalls, and reports the verdict.
// ----------------------------------------------------------------------------
module swerve_wheel_speed_direction_test;

  localparam int LATENCY = 61;
  localparam int STALL_LIMIT = 20000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  logic         cfg_we;
  logic [3:0]   cfg_index;
  logic [13:0]  cfg_data;
  int           fail_count;
  int           pending;
  int           result_count;
  int           sent_count;
  int           idle_cycles;
  bit           long_hold;
  bit           sending_done;

  swerve_wheel_speed_direction dut (.*);

  swerve_wheel_speed_direction_monitor monitor (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // offer one request and hold it until accepted; valid stays high afterwards
  task automatic offer_command(logic [63:0] data);
    s_tvalid <= 1'b1;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  // send one drive command, waiting out a random gap first
  task automatic send_command(logic [15:0] vx, logic [15:0] vy, logic [15:0] spin,
                              logic [15:0] heading);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    offer_command({heading, spin, vy, vx});
  endtask

  task automatic write_mult(int index, logic [13:0] value);
    cfg_we <= 1'b1;
    cfg_index <= 4'(index);
    cfg_data <= value;
    @(negedge clk);
  endtask

  // wait for the pipeline to drain, then load a new multiplier set
  task automatic load_wheels(int mode);
    logic [13:0] v;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    for (int i = 0; i < swd_pkg::REG_COUNT; i++) begin
      case (mode)
        0: v = 14'sd4096;
        1: v = -14'sd4096;
        2: v = (i % 2) ? 14'sd4096 : -14'sd4096;
        default: v = 14'($signed($urandom_range(0, 8192)) - 4096);
      endcase
      write_mult(i, v);
    end
    write_mult(swd_pkg::REG_COUNT + $urandom_range(0, 7), 14'h1555);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls, one long hold-off to fill the pipeline
  initial begin
    int wait_cycles;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
      if (sent_count > 400 && sent_count < 480) wait_cycles = 0;
      if (wait_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || long_hold) begin
      idle_cycles <= 0;
    end else if (!sending_done || pending != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] edge_vals [4];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent_count = 0;
    long_hold = 1'b0;
    sending_done = 1'b0;
    edge_vals = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset multipliers (zero): zero vector and plain translation
    send_command(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_command(16'h0000, 16'h0000, 16'h7FFF, 16'h4000);
    send_command(16'h1000, 16'h0000, 16'h0000, 16'h0000);
    load_wheels(0);
    // heading extremes and quarter-turn folds, saturation, normalization
    for (int i = 0; i < 4; i++) begin
      send_command(edge_vals[i], edge_vals[3 - i], edge_vals[i], 16'h0000);
      send_command(edge_vals[i], edge_vals[i], 16'h1000, 16'hC000 + 16'(i));
      send_command(16'h0800, 16'hF800, edge_vals[i], 16'h8000 - 16'(i));
    end
    send_command(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_command(16'h0010, 16'h0000, 16'h0001, 16'h3FFF);
    load_wheels(1);
    send_command(16'h7FFF, 16'h7FFF, 16'h8000, 16'h4001);
    send_command(16'h0000, 16'h0000, 16'h0000, 16'h4000);
    load_wheels(2);
    send_command(16'h8000, 16'h8000, 16'h7FFF, 16'hBFFF);

    // random commands over several multiplier sets
    for (int n = 0; n < 750; n++) begin
      if (n % 200 == 199) load_wheels(n == 399 ? 2 : 3);
      if (n == 400) long_hold = 1'b1;
      if (n >= 400 && n < 480) begin
        offer_command({16'($urandom), rand_field(), rand_field(), rand_field()});
      end else begin
        send_command(rand_field(), rand_field(), rand_field(), 16'($urandom));
      end
    end
    s_tvalid <= 1'b0;
    sending_done = 1'b1;

    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("Sent %0d drive commands over several multiplier sets; %0d wheel results checked.",
             sent_count, result_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
